// ===== design/idll_pkg.sv =====
package idll_pkg;

  // fixed field widths of the channels
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;

  // command codes
  localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // write enables of the node store, one per array
  typedef struct packed {
    logic value;
    logic prev;
    logic next;
    logic live;
  } wr_en_t;

endpackage

// ===== design/indexed_doubly_linked_list_core.sv =====
// channel | ports                                                | dir | handshake
// --------+------------------------------------------------------+-----+----------------------
// command | in_mode, in_position, in_value                       | in  | start high, busy low
// result  | out_status, out_node_index, out_node_value, out_last | out | out_strobe, one cycle
//
// insert steps: accept read, lookup, new node write, neighbor link fix-up
// erase, pool full, bad position and unused mode steps: accept read, lookup
// traverse steps: accept read, then one next-link read and beat per node; one beat on an empty list
// each beat shows on the output registers in the cycle after it is formed; no receiver stall
// synchronous reset with no clearing pass: live marks at or above the allocation count
// are never trusted, and the head's forward link lives in a register
module indexed_doubly_linked_list_core #(
  parameter int POOL_DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  localparam int IDX_W = $clog2(POOL_DEPTH),
  localparam int NF_W = IDX_W + 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [idll_pkg::MODE_W-1:0]          in_mode,
  input  logic [IDX_W-1:0]                     in_position,
  input  logic signed [idll_pkg::VALUE_W-1:0]  in_value,
  output logic                                 out_strobe,
  output logic [idll_pkg::STATUS_W-1:0]        out_status,
  output logic [IDX_W-1:0]                     out_node_index,
  output logic signed [idll_pkg::VALUE_W-1:0]  out_node_value,
  output logic                                 out_last
);

  localparam int VW = idll_pkg::VALUE_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_LINK = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [NF_W-1:0]             next_free_r, next_free_nxt;
  logic [IDX_W-1:0]            head_next_r, head_next_nxt;
  logic [idll_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [IDX_W-1:0]            pos_r, pos_nxt;
  logic [VW-1:0]               value_r, value_nxt;
  logic [IDX_W-1:0]            cur_r, cur_nxt;
  logic [IDX_W-1:0]            count_r, count_nxt;
  logic [IDX_W-1:0]            after_r, after_nxt;

  logic                          out_strobe_r;
  logic [idll_pkg::STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]              out_index_r;
  logic [VW-1:0]                 out_value_r;
  logic                          out_last_r;

  // result being formed this cycle
  logic                          emit;
  logic [idll_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]              res_index;
  logic [VW-1:0]                 res_value;
  logic                          res_last;

  // node store ports
  logic [IDX_W-1:0]      rd_addr;
  logic [DATA_WIDTH-1:0] rd_value;
  logic [IDX_W-1:0]      rd_prev;
  logic [IDX_W-1:0]      rd_next;
  logic                  rd_live;
  idll_pkg::wr_en_t      we;
  logic [IDX_W-1:0]      value_addr;
  logic [DATA_WIDTH-1:0] value_data;
  logic [IDX_W-1:0]      prev_addr;
  logic [IDX_W-1:0]      prev_data;
  logic [IDX_W-1:0]      next_addr;
  logic [IDX_W-1:0]      next_data;
  logic [IDX_W-1:0]      live_addr;
  logic                  live_data;

  logic [DATA_WIDTH-1:0] store_value;
  logic [VW-1:0]         wide_value;
  logic                  pool_full;
  logic                  pos_live;
  logic                  walk_last;
  logic [IDX_W-1:0]      new_node;

  idll_node_store #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk        (clk),
    .rd_addr    (rd_addr),
    .rd_value   (rd_value),
    .rd_prev    (rd_prev),
    .rd_next    (rd_next),
    .rd_live    (rd_live),
    .we         (we),
    .value_addr (value_addr),
    .value_data (value_data),
    .prev_addr  (prev_addr),
    .prev_data  (prev_data),
    .next_addr  (next_addr),
    .next_data  (next_data),
    .live_addr  (live_addr),
    .live_data  (live_data)
  );

  // data word fitting: narrow store truncates on store and sign-extends on read; wide store zero-extends and truncates
  generate
    if (DATA_WIDTH >= VW) begin : g_wide
      assign store_value = DATA_WIDTH'(value_r);
      assign wide_value  = rd_value[VW-1:0];
    end else begin : g_narrow
      assign store_value = value_r[DATA_WIDTH-1:0];
      assign wide_value  = {{(VW-DATA_WIDTH){rd_value[DATA_WIDTH-1]}}, rd_value};
    end
  endgenerate

  // lookup checks on the read data
  assign new_node  = next_free_r[IDX_W-1:0];
  assign pool_full = (next_free_r >= NF_W'(POOL_DEPTH));
  assign pos_live  = (pos_r == '0) || (({1'b0, pos_r} < next_free_r) && rd_live);
  assign walk_last = (rd_next == '0) || (count_r == IDX_W'(POOL_DEPTH - 2));

  // read address: command position at accept (head link for a traverse), next link while walking
  always_comb begin
    if (state_r == S_WALK) begin
      rd_addr = rd_next;
    end else if (in_mode == idll_pkg::MODE_TRAVERSE) begin
      rd_addr = head_next_r;
    end else begin
      rd_addr = in_position;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    next_free_nxt = next_free_r;
    head_next_nxt = head_next_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    value_nxt     = value_r;
    cur_nxt       = cur_r;
    count_nxt     = count_r;
    after_nxt     = after_r;
    emit          = 1'b0;
    res_status    = idll_pkg::ST_OK;
    res_index     = '0;
    res_value     = '0;
    res_last      = 1'b1;
    we            = '0;
    value_addr    = new_node;
    value_data    = store_value;
    prev_addr     = new_node;
    prev_data     = pos_r;
    next_addr     = new_node;
    next_data     = after_r;
    live_addr     = new_node;
    live_data     = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = in_mode;
          pos_nxt   = in_position;
          value_nxt = in_value;
          cur_nxt   = head_next_r;
          count_nxt = '0;
          state_nxt = (in_mode == idll_pkg::MODE_TRAVERSE) ? S_WALK : S_LOOK;
        end
      end
      S_LOOK: begin
        case (mode_r)
          idll_pkg::MODE_INSERT: begin
            if (pool_full) begin
              emit       = 1'b1;
              res_status = idll_pkg::ST_FULL;
              state_nxt  = S_IDLE;
            end else if (!pos_live) begin
              emit       = 1'b1;
              res_status = idll_pkg::ST_BAD;
              state_nxt  = S_IDLE;
            end else begin
              after_nxt = (pos_r == '0) ? head_next_r : rd_next;
              state_nxt = S_LINK;
            end
          end
          idll_pkg::MODE_ERASE: begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (pos_r == '0 || !pos_live) begin
              res_status = idll_pkg::ST_BAD;
            end else begin
              // bypass the node in both directions
              if (rd_prev == '0) begin
                head_next_nxt = rd_next;
              end else begin
                we.next   = 1'b1;
                next_addr = rd_prev;
                next_data = rd_next;
              end
              we.prev   = (rd_next != '0);
              prev_addr = rd_next;
              prev_data = rd_prev;
              we.live   = 1'b1;
              live_addr = pos_r;
              live_data = 1'b0;
            end
          end
          default: begin
            emit       = 1'b1;
            res_status = idll_pkg::ST_BAD;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_LINK: begin
        // fill the new node
        we.value  = 1'b1;
        we.prev   = 1'b1;
        we.next   = 1'b1;
        we.live   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        // hook the new node into its neighbors
        if (pos_r == '0) begin
          head_next_nxt = new_node;
        end else begin
          we.next   = 1'b1;
          next_addr = pos_r;
          next_data = new_node;
        end
        we.prev       = (after_r != '0);
        prev_addr     = after_r;
        prev_data     = new_node;
        next_free_nxt = next_free_r + NF_W'(1);
        emit          = 1'b1;
        res_index     = new_node;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        emit = 1'b1;
        if (cur_r == '0) begin
          res_status = idll_pkg::ST_EMPTY;
          state_nxt  = S_IDLE;
        end else begin
          res_index = cur_r;
          res_value = wide_value;
          res_last  = walk_last;
          if (walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt   = rd_next;
            count_nxt = count_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      next_free_r  <= NF_W'(1);
      head_next_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_free_r  <= next_free_nxt;
      head_next_r  <= head_next_nxt;
      out_strobe_r <= emit;
    end
  end

  // command and walk payload
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    pos_r   <= pos_nxt;
    value_r <= value_nxt;
    cur_r   <= cur_nxt;
    count_r <= count_nxt;
    after_r <= after_nxt;
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_value_r  <= res_value;
      out_last_r   <= res_last;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_index_r;
  assign out_node_value = out_value_r;
  assign out_last       = out_last_r;

  // a result beat is only formed while an item is in work
  a_strobe_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r != S_IDLE))
    else $error("result beat without an item in work");

  // allocation count stays inside the pool
  a_free_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NF_W'(POOL_DEPTH) && next_free_r != '0)
    else $error("allocation count out of range");

  // the head points to an allocated node or to end of list
  a_head_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_next_r} < next_free_r)
    else $error("head link points to an unallocated node");

  // an accepted command always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not start work");

  // the final beat of an item is followed by a gap
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("beat directly after a final beat");

endmodule

// ===== design/idll_node_store.sv =====
module idll_node_store #(
  parameter int POOL_DEPTH = 64,
  parameter int DATA_WIDTH = 32,
  localparam int IDX_W = $clog2(POOL_DEPTH)
) (
  input  logic                  clk,
  // shared read address, data registered and shown in the cycle after
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [DATA_WIDTH-1:0] rd_value,
  output logic [IDX_W-1:0]      rd_prev,
  output logic [IDX_W-1:0]      rd_next,
  output logic                  rd_live,
  // one write port per array
  input  idll_pkg::wr_en_t      we,
  input  logic [IDX_W-1:0]      value_addr,
  input  logic [DATA_WIDTH-1:0] value_data,
  input  logic [IDX_W-1:0]      prev_addr,
  input  logic [IDX_W-1:0]      prev_data,
  input  logic [IDX_W-1:0]      next_addr,
  input  logic [IDX_W-1:0]      next_data,
  input  logic [IDX_W-1:0]      live_addr,
  input  logic                  live_data
);

  logic [DATA_WIDTH-1:0] value_mem [POOL_DEPTH];
  logic [IDX_W-1:0]      prev_mem  [POOL_DEPTH];
  logic [IDX_W-1:0]      next_mem  [POOL_DEPTH];
  logic                  live_mem  [POOL_DEPTH];

  // data words
  always_ff @(posedge clk) begin
    if (we.value) begin
      value_mem[value_addr] <= value_data;
    end
    rd_value <= value_mem[rd_addr];
  end

  // backward links
  always_ff @(posedge clk) begin
    if (we.prev) begin
      prev_mem[prev_addr] <= prev_data;
    end
    rd_prev <= prev_mem[rd_addr];
  end

  // forward links
  always_ff @(posedge clk) begin
    if (we.next) begin
      next_mem[next_addr] <= next_data;
    end
    rd_next <= next_mem[rd_addr];
  end

  // live marks, meaningful only below the allocation count
  always_ff @(posedge clk) begin
    if (we.live) begin
      live_mem[live_addr] <= live_data;
    end
    rd_live <= live_mem[rd_addr];
  end

endmodule

// ===== test/idll_checker.sv =====
`timescale 1ns / 1ps

module idll_checker #(
  parameter int POOL_DEPTH = 64,
  localparam int IDX_W = $clog2(POOL_DEPTH),
  localparam int NF_W = IDX_W + 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic [idll_pkg::MODE_W-1:0]          in_mode,
  input  logic [IDX_W-1:0]                     in_position,
  input  logic signed [idll_pkg::VALUE_W-1:0]  in_value,
  input  logic                                 out_strobe,
  input  logic [idll_pkg::STATUS_W-1:0]        out_status,
  input  logic [IDX_W-1:0]                     out_node_index,
  input  logic signed [idll_pkg::VALUE_W-1:0]  out_node_value,
  input  logic                                 out_last,
  output int                                   fail_total,
  output int                                   reports_pending
);

  // one result beat as the block should present it
  typedef struct {
    logic [idll_pkg::STATUS_W-1:0]       status;
    logic [IDX_W-1:0]                    node_index;
    logic signed [idll_pkg::VALUE_W-1:0] node_value;
    logic                                last;
  } node_report_t;

  // shadow copy of the node pool
  logic signed [idll_pkg::VALUE_W-1:0] shadow_value [POOL_DEPTH];
  logic [IDX_W-1:0]                    shadow_prev  [POOL_DEPTH];
  logic [IDX_W-1:0]                    shadow_next  [POOL_DEPTH];
  bit                                  shadow_live  [POOL_DEPTH];
  logic [NF_W-1:0]                     shadow_free;

  node_report_t node_reports [$];
  int           fails = 0;

  function automatic node_report_t make_report(logic [idll_pkg::STATUS_W-1:0] status,
                                               logic [IDX_W-1:0] idx,
                                               logic signed [idll_pkg::VALUE_W-1:0] value,
                                               logic last);
    node_report_t r;
    r.status     = status;
    r.node_index = idx;
    r.node_value = value;
    r.last       = last;
    return r;
  endfunction

  // apply one command to the shadow list and queue the beats it should cause
  task automatic run_list_command(logic [idll_pkg::MODE_W-1:0] mode,
                                  logic [IDX_W-1:0] pos,
                                  logic signed [idll_pkg::VALUE_W-1:0] value);
    logic [IDX_W-1:0] fresh;
    logic [IDX_W-1:0] succ;
    logic [IDX_W-1:0] pred;
    logic [IDX_W-1:0] cur;
    int               visited;
    case (mode)
      idll_pkg::MODE_INSERT: begin
        if (shadow_free >= POOL_DEPTH) begin
          node_reports.push_back(make_report(idll_pkg::ST_FULL, '0, '0, 1'b1));
        end else if (!shadow_live[pos]) begin
          node_reports.push_back(make_report(idll_pkg::ST_BAD, '0, '0, 1'b1));
        end else begin
          fresh = shadow_free[IDX_W-1:0];
          succ  = shadow_next[pos];
          shadow_value[fresh] = value;
          shadow_prev[fresh]  = pos;
          shadow_next[fresh]  = succ;
          if (succ != 0) shadow_prev[succ] = fresh;
          shadow_next[pos]    = fresh;
          shadow_live[fresh]  = 1'b1;
          shadow_free         = shadow_free + 1'b1;
          node_reports.push_back(make_report(idll_pkg::ST_OK, fresh, '0, 1'b1));
        end
      end
      idll_pkg::MODE_ERASE: begin
        if (pos == 0 || !shadow_live[pos]) begin
          node_reports.push_back(make_report(idll_pkg::ST_BAD, '0, '0, 1'b1));
        end else begin
          pred = shadow_prev[pos];
          succ = shadow_next[pos];
          shadow_next[pred] = succ;
          if (succ != 0) shadow_prev[succ] = pred;
          shadow_live[pos] = 1'b0;
          node_reports.push_back(make_report(idll_pkg::ST_OK, '0, '0, 1'b1));
        end
      end
      idll_pkg::MODE_TRAVERSE: begin
        cur = shadow_next[0];
        visited = 0;
        if (cur == 0) begin
          node_reports.push_back(make_report(idll_pkg::ST_EMPTY, '0, '0, 1'b1));
        end else begin
          while (cur != 0 && visited < POOL_DEPTH - 1) begin
            succ = shadow_next[cur];
            node_reports.push_back(make_report(idll_pkg::ST_OK, cur, shadow_value[cur],
                (succ == 0) || (visited + 1 >= POOL_DEPTH - 1)));
            visited++;
            cur = succ;
          end
        end
      end
      default: begin
        // unused mode code
        node_reports.push_back(make_report(idll_pkg::ST_BAD, '0, '0, 1'b1));
      end
    endcase
  endtask

  // compare result beats, then take in accepted commands
  always @(posedge clk) begin
    node_report_t want;
    if (!rst_n) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        shadow_value[i] = '0;
        shadow_prev[i]  = '0;
        shadow_next[i]  = '0;
        shadow_live[i]  = (i == 0);
      end
      shadow_free = NF_W'(1);
      node_reports.delete();
    end else begin
      if (out_strobe) begin
        if (node_reports.size() == 0) begin
          $error("result beat with nothing expected: status %0d index %0d value %0d",
                 out_status, out_node_index, out_node_value);
          fails++;
        end else begin
          want = node_reports.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_node_index !== want.node_index) begin
            $error("node_index: expected %0d, got %0d", want.node_index, out_node_index);
            fails++;
          end
          if (out_node_value !== want.node_value) begin
            $error("node_value: expected %0d, got %0d", want.node_value, out_node_value);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            fails++;
          end
        end
      end
      if (start && !busy) run_list_command(in_mode, in_position, in_value);
    end
    fail_total      <= fails;
    reports_pending <= node_reports.size();
  end

endmodule

// ===== test/indexed_doubly_linked_list_core_tb.sv =====
`timescale 1ns / 1ps

module indexed_doubly_linked_list_core_tb;

  localparam int POOL_DEPTH  = 64;
  localparam int IDX_W       = $clog2(POOL_DEPTH);
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_CMDS = 360;
  localparam int DRAIN_WAIT  = 16;

  // the one mode code the block does not implement
  localparam logic [idll_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [idll_pkg::MODE_W-1:0]          in_mode = '0;
  logic [IDX_W-1:0]                     in_position = '0;
  logic signed [idll_pkg::VALUE_W-1:0]  in_value = '0;
  logic                                 out_strobe;
  logic [idll_pkg::STATUS_W-1:0]        out_status;
  logic [IDX_W-1:0]                     out_node_index;
  logic signed [idll_pkg::VALUE_W-1:0]  out_node_value;
  logic                                 out_last;
  int                                   fail_total;
  int                                   reports_pending;
  int                                   cycles = 0;

  // stimulus-side view of which nodes are linked, for picking positions
  bit                         node_alive [POOL_DEPTH];
  int                         nodes_used = 1;
  bit                         quiet_stretch = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  indexed_doubly_linked_list_core #(
    .POOL_DEPTH(POOL_DEPTH),
    .DATA_WIDTH(32)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_node_index(out_node_index),
    .out_node_value(out_node_value),
    .out_last      (out_last)
  );

  idll_checker #(
    .POOL_DEPTH(POOL_DEPTH)
  ) checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_node_index (out_node_index),
    .out_node_value (out_node_value),
    .out_last       (out_last),
    .fail_total     (fail_total),
    .reports_pending(reports_pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // random linked node, optionally leaving out the head
  function automatic logic [IDX_W-1:0] pick_linked(bit skip_head);
    int picks [$];
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (node_alive[i] && !(skip_head && i == 0)) picks.push_back(i);
    end
    if (picks.size() == 0) return '0;
    return IDX_W'(picks[$urandom_range(picks.size() - 1)]);
  endfunction

  // present one command beat and hold it until the block takes it
  task automatic send_command(logic [idll_pkg::MODE_W-1:0] mode, logic [IDX_W-1:0] pos,
                              logic signed [idll_pkg::VALUE_W-1:0] value);
    int gap;
    if (!quiet_stretch && $urandom_range(99) < 20) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= mode;
    in_position <= pos;
    in_value    <= value;
    do @(posedge clk); while (busy);
    // track linkage so later positions can aim at live nodes
    if (mode == idll_pkg::MODE_INSERT && nodes_used < POOL_DEPTH && node_alive[pos]) begin
      node_alive[nodes_used] = 1'b1;
      nodes_used++;
    end else if (mode == idll_pkg::MODE_ERASE && pos != 0 && node_alive[pos]) begin
      node_alive[pos] = 1'b0;
    end
  endtask

  initial begin
    int                                  roll;
    logic [IDX_W-1:0]                    pos;
    logic signed [idll_pkg::VALUE_W-1:0] value;
    for (int i = 0; i < POOL_DEPTH; i++) node_alive[i] = (i == 0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, bad positions, extremes, head and tail edits
    send_command(idll_pkg::MODE_TRAVERSE, 6'd0, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd0, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd5, 32'sd0);
    send_command(idll_pkg::MODE_INSERT, 6'd7, 32'sd12);
    send_command(MODE_UNUSED, 6'd63, -32'sd1);
    send_command(idll_pkg::MODE_INSERT, 6'd0, 32'h7fff_ffff);
    send_command(idll_pkg::MODE_INSERT, 6'd0, 32'h8000_0000);
    send_command(idll_pkg::MODE_INSERT, 6'd1, -32'sd1);
    send_command(idll_pkg::MODE_INSERT, 6'd2, 32'sd0);
    send_command(idll_pkg::MODE_TRAVERSE, 6'd63, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd3, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd2, 32'sd0);
    send_command(idll_pkg::MODE_TRAVERSE, 6'd0, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd2, 32'sd0);
    send_command(idll_pkg::MODE_INSERT, 6'd2, 32'sd99);
    send_command(idll_pkg::MODE_ERASE, 6'd63, 32'sd0);
    send_command(idll_pkg::MODE_INSERT, 6'd4, 32'h5555_5555);
    send_command(idll_pkg::MODE_TRAVERSE, 6'd0, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd4, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd1, 32'sd0);
    send_command(idll_pkg::MODE_ERASE, 6'd5, 32'sd0);
    send_command(idll_pkg::MODE_TRAVERSE, 6'd0, 32'sd0);

    // random: mostly edits at live nodes, some wild positions and bad modes
    for (int k = 0; k < RANDOM_CMDS; k++) begin
      quiet_stretch = (k >= 140 && k < 220);
      roll  = $urandom_range(99);
      value = $urandom;
      if ($urandom_range(9) == 0) begin
        value = ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      end
      if (roll < 45) begin
        pos = ($urandom_range(9) < 8) ? pick_linked(1'b0) : IDX_W'($urandom_range(63));
        send_command(idll_pkg::MODE_INSERT, pos, value);
      end else if (roll < 65) begin
        pos = ($urandom_range(9) < 8) ? pick_linked(1'b1) : IDX_W'($urandom_range(63));
        send_command(idll_pkg::MODE_ERASE, pos, value);
      end else if (roll < 95) begin
        send_command(idll_pkg::MODE_TRAVERSE, IDX_W'($urandom_range(63)), value);
      end else begin
        send_command(MODE_UNUSED, IDX_W'($urandom_range(63)), value);
      end
    end
    start <= 1'b0;

    // drain outstanding beats, then allow for stray ones
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/idll_pkg.sv
design/idll_node_store.sv
design/indexed_doubly_linked_list_core.sv
test/idll_checker.sv
test/indexed_doubly_linked_list_core_tb.sv
